>>> src/smc3_pkg.sv
// shared types, constants and tables for the sample mean and covariance block
`timescale 1ns / 1ps
`default_nettype none
package smc3_pkg;

   localparam int MAX_SAMPLES_DEF = 1024;
   localparam int COMP_WIDTH_DEF  = 32;
   localparam int FIELD_WIDTH     = 32;
   localparam int COV_WIDTH       = 64;
   localparam int NUM_COMP        = 3;
   localparam int NUM_PAIR        = 6;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_TOO_FEW = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;

   typedef struct packed {
      logic clear;
      logic valid;
   } lane_ctl_type;

   // upper-triangle pair k -> row and column component
   function automatic int pair_row(input int k);
      case (k)
         0, 1, 2: pair_row = 0;
         3, 4:    pair_row = 1;
         default: pair_row = 2;
      endcase
   endfunction

   function automatic int pair_col(input int k);
      case (k)
         0:       pair_col = 0;
         1, 3:    pair_col = 1;
         default: pair_col = 2;
      endcase
   endfunction

   // full matrix (row, col) -> upper-triangle pair
   function automatic logic [2:0] tri_index(input logic [1:0] r, input logic [1:0] c);
      logic [3:0] key;
      key = {r, c};
      case (key)
         4'b0000: tri_index = 3'd0;
         4'b0001, 4'b0100: tri_index = 3'd1;
         4'b0010, 4'b1000: tri_index = 3'd2;
         4'b0101: tri_index = 3'd3;
         4'b0110, 4'b1001: tri_index = 3'd4;
         default: tri_index = 3'd5;
      endcase
   endfunction

endpackage
`default_nettype wire

>>> src/smc3_if.sv
// sample and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface smc3_req_if;
   logic valid;
   logic ready;
   logic [smc3_pkg::FIELD_WIDTH-1:0] sample_x;
   logic [smc3_pkg::FIELD_WIDTH-1:0] sample_y;
   logic [smc3_pkg::FIELD_WIDTH-1:0] sample_z;
   logic is_final;
   modport source (output valid, sample_x, sample_y, sample_z, is_final, input ready);
   modport sink (input valid, sample_x, sample_y, sample_z, is_final, output ready);
endinterface

interface smc3_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] row_index;
   logic [smc3_pkg::FIELD_WIDTH-1:0] mean_value;
   logic [smc3_pkg::COV_WIDTH-1:0] cov_col0;
   logic [smc3_pkg::COV_WIDTH-1:0] cov_col1;
   logic [smc3_pkg::COV_WIDTH-1:0] cov_col2;
   logic [1:0] status;
   logic row_last;
   modport source (output valid, row_index, mean_value, cov_col0, cov_col1, cov_col2,
                   status, row_last, input ready);
   modport sink (input valid, row_index, mean_value, cov_col0, cov_col1, cov_col2,
                 status, row_last, output ready);
endinterface
`default_nettype wire

>>> src/smc3_div.sv
// restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module smc3_div #(
   parameter int W   = 64,
   parameter int DVW = 11
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [W-1:0]   dividend,
   input  wire logic [DVW-1:0] divisor,
   output logic                busy,
   output logic                done,
   output logic [W-1:0]        quotient
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]   quo_ff, quo_in;
   logic [DVW:0]   rem_ff, rem_in;
   logic [DVW-1:0] dvs_ff;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in, done_ff, done_in;
   logic [DVW:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DVW-1:0], quo_ff[W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) dvs_ff <= divisor;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

>>> src/smc3_lane.sv
// one covariance lane: split product of two deviations and running sum
`timescale 1ns / 1ps
`default_nettype none
module smc3_lane #(
   parameter int DW = 33,
   parameter int AW = 77
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire smc3_pkg::lane_ctl_type ctl,
   input  wire logic signed [DW-1:0]  dev_a,
   input  wire logic signed [DW-1:0]  dev_b,
   output logic                       busy,
   output logic signed [AW-1:0]       acc
);
   localparam int LW = DW / 2;
   localparam int HW = DW - LW;

   logic signed [DW+LW:0]   plo_ff, plo_in;
   logic signed [DW+HW-1:0] phi_ff, phi_in;
   logic                    pv_ff;
   logic signed [AW-1:0]    acc_ff, acc_in, prod;

   always_comb begin
      plo_in = dev_a * $signed({1'b0, dev_b[LW-1:0]});
      phi_in = dev_a * $signed(dev_b[DW-1:LW]);
      prod   = ($signed({{(AW-DW-HW){phi_ff[DW+HW-1]}}, phi_ff}) <<< LW)
             + $signed({{(AW-DW-LW-1){plo_ff[DW+LW]}}, plo_ff});
      acc_in = acc_ff;
      if (ctl.clear) acc_in = '0;
      else if (pv_ff) acc_in = acc_ff + prod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         pv_ff  <= ctl.valid;
         acc_ff <= acc_in;
      end
      plo_ff <= plo_in;
      phi_ff <= phi_in;
   end

   assign busy = pv_ff;
   assign acc  = acc_ff;
endmodule
`default_nettype wire

>>> src/sample_mean_covariance_3d_core.sv
// top level: sample store, sequencing, lanes, divider and result rows
`timescale 1ns / 1ps
`default_nettype none
// Samples are written to an on-chip store at one per cycle while a set loads; ready is
// high only in that phase. After the final sample the shared serial divider forms the
// three means (one quotient bit per cycle over AW bits, AW = 2*COMPONENT_WIDTH + 2 +
// clog2(MAX_SAMPLES+1)), then the store is swept once at one sample per cycle through
// six parallel product lanes, then the same divider forms the six covariance terms. With
// N < 2 the sweep and the covariance terms are skipped. Three result beats close the set.
module sample_mean_covariance_3d_core #(
   parameter int MAX_SAMPLES     = smc3_pkg::MAX_SAMPLES_DEF,
   parameter int COMPONENT_WIDTH = smc3_pkg::COMP_WIDTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   smc3_req_if.sink   req_bus,
   smc3_rsp_if.source rsp_bus
);
   localparam int CW   = COMPONENT_WIDTH;
   localparam int CNTW = $clog2(MAX_SAMPLES + 1);
   localparam int ADW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int SW   = CW + CNTW;
   localparam int DW   = CW + 1;
   localparam int AW   = 2 * DW + CNTW;
   localparam int MXW  = ((CW > 32) ? CW : 32) + 1;
   localparam int QXW  = ((AW > 64) ? AW : 64) + 1;
   localparam int FW   = smc3_pkg::FIELD_WIDTH;
   localparam int VW   = smc3_pkg::COV_WIDTH;

   typedef enum logic [2:0] {LOAD, DIV, SWEEP, EMIT} state_type;

   state_type state_ff, state_in;
   logic [CNTW-1:0] count_ff, count_in, rd_addr_ff, rd_addr_in;
   logic            ovf_ff, ovf_in, issued_ff, issued_in, neg_ff;
   logic            rd_on_ff, rd_on_in, rd_vld_ff, dev_vld_ff;
   logic [3:0]      job_ff, job_in, job_cov;
   logic [1:0]      row_ff, row_in, status;
   logic signed [SW-1:0] sum_ff [smc3_pkg::NUM_COMP];
   logic signed [SW-1:0] sum_in [smc3_pkg::NUM_COMP];
   logic signed [CW-1:0] mean_ff [smc3_pkg::NUM_COMP];
   logic [VW-1:0]        cov_ff [smc3_pkg::NUM_PAIR];
   logic signed [DW-1:0] dev_ff [smc3_pkg::NUM_COMP];
   logic [3*CW-1:0]      store [MAX_SAMPLES];
   logic [3*CW-1:0]      mem_q_ff, wr_word;
   logic [CW-1:0]        comp_in [smc3_pkg::NUM_COMP];

   logic          req_acc, rsp_acc, div_start, div_busy, div_done, lane_clear, lanes_busy;
   logic [AW-1:0] div_dvd, div_q;
   logic [CNTW-1:0] div_dvs;
   logic          neg_cur;
   logic [SW-1:0] sum_mag;
   logic signed [AW-1:0] acc_sel;
   logic signed [AW-1:0] lane_acc [smc3_pkg::NUM_PAIR];
   logic [smc3_pkg::NUM_PAIR-1:0] lane_busy;
   logic [QXW-1:0] q_ext, q_lim;
   logic [VW-1:0]  cov_res;
   logic [AW-1:0]  q_signed;
   logic signed [MXW-1:0] mean_x;
   logic [FW-1:0]  mean_out;
   smc3_pkg::lane_ctl_type lane_ctl;

   // component as two's complement within CW bits
   function automatic logic [CW-1:0] take_comp(input logic [FW-1:0] v);
      logic [63:0] t;
      t = {32'b0, v};
      return t[CW-1:0];
   endfunction

   assign comp_in[0] = take_comp(req_bus.sample_x);
   assign comp_in[1] = take_comp(req_bus.sample_y);
   assign comp_in[2] = take_comp(req_bus.sample_z);
   assign wr_word    = {comp_in[2], comp_in[1], comp_in[0]};

   assign req_bus.ready = (state_ff == LOAD);
   assign req_acc = req_bus.valid && req_bus.ready;
   assign rsp_acc = rsp_bus.valid && rsp_bus.ready;
   assign job_cov = job_ff - 4'd3;

   // divider job select: means first, then covariance terms
   always_comb begin
      sum_mag = '0;
      acc_sel = '0;
      if (job_ff < 4'd3) begin
         neg_cur = sum_ff[job_ff[1:0]][SW-1];
         sum_mag = neg_cur ? SW'(-sum_ff[job_ff[1:0]]) : SW'(sum_ff[job_ff[1:0]]);
         div_dvd = {{(AW-SW){1'b0}}, sum_mag};
         div_dvs = count_ff;
      end else begin
         acc_sel = lane_acc[job_cov[2:0]];
         neg_cur = acc_sel[AW-1];
         div_dvd = neg_cur ? AW'(-acc_sel) : AW'(acc_sel);
         div_dvs = count_ff - 1'b1;
      end
   end

   assign div_start = (state_ff == DIV) && !issued_ff && !div_busy;

   // signed quotient and covariance saturation
   always_comb begin
      q_signed = neg_ff ? AW'(-div_q) : div_q;
      q_ext    = {{(QXW-AW){1'b0}}, div_q};
      q_lim    = neg_ff ? (QXW'(1) << 63) : ((QXW'(1) << 63) - 1'b1);
      if (q_ext > q_lim) q_ext = q_lim;
      cov_res  = neg_ff ? VW'(-q_ext) : VW'(q_ext);
   end

   assign lanes_busy = |lane_busy;
   assign lane_clear = (state_ff == DIV) && div_done && (job_ff == 4'd2)
                     && (count_ff >= CNTW'(2));
   assign lane_ctl   = '{clear: lane_clear, valid: dev_vld_ff};

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      issued_in  = issued_ff;
      job_in     = job_ff;
      row_in     = row_ff;
      rd_addr_in = rd_addr_ff;
      rd_on_in   = rd_on_ff;
      for (int c = 0; c < smc3_pkg::NUM_COMP; c++) sum_in[c] = sum_ff[c];
      unique case (state_ff)
         LOAD: begin
            if (req_acc) begin
               if (count_ff < CNTW'(MAX_SAMPLES)) begin
                  count_in = count_ff + 1'b1;
                  for (int c = 0; c < smc3_pkg::NUM_COMP; c++)
                     sum_in[c] = sum_ff[c] + $signed({{CNTW{comp_in[c][CW-1]}}, comp_in[c]});
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_bus.is_final) begin
                  state_in = DIV;
                  job_in   = '0;
               end
            end
         end
         DIV: begin
            if (div_start) issued_in = 1'b1;
            if (div_done) begin
               issued_in = 1'b0;
               job_in    = job_ff + 1'b1;
               if (job_ff == 4'd2) begin
                  if (count_ff >= CNTW'(2)) begin
                     state_in   = SWEEP;
                     rd_addr_in = '0;
                     rd_on_in   = 1'b1;
                  end else begin
                     state_in = EMIT;
                  end
               end else if (job_ff == 4'd8) begin
                  state_in = EMIT;
               end
            end
         end
         SWEEP: begin
            if (rd_on_ff) begin
               rd_addr_in = rd_addr_ff + 1'b1;
               if (rd_addr_ff == count_ff - 1'b1) rd_on_in = 1'b0;
            end else if (!rd_vld_ff && !dev_vld_ff && !lanes_busy) begin
               state_in = DIV;
            end
         end
         EMIT: begin
            if (rsp_acc) begin
               row_in = row_ff + 1'b1;
               if (row_ff == 2'd2) begin
                  state_in = LOAD;
                  row_in   = '0;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  for (int c = 0; c < smc3_pkg::NUM_COMP; c++) sum_in[c] = '0;
               end
            end
         end
         default: state_in = LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= LOAD;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         issued_ff  <= 1'b0;
         job_ff     <= '0;
         row_ff     <= '0;
         rd_addr_ff <= '0;
         rd_on_ff   <= 1'b0;
         rd_vld_ff  <= 1'b0;
         dev_vld_ff <= 1'b0;
         for (int c = 0; c < smc3_pkg::NUM_COMP; c++) sum_ff[c] <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         issued_ff  <= issued_in;
         job_ff     <= job_in;
         row_ff     <= row_in;
         rd_addr_ff <= rd_addr_in;
         rd_on_ff   <= rd_on_in;
         rd_vld_ff  <= rd_on_ff;
         dev_vld_ff <= rd_vld_ff;
         for (int c = 0; c < smc3_pkg::NUM_COMP; c++) sum_ff[c] <= sum_in[c];
      end
      if (div_start) neg_ff <= neg_cur;
      if ((state_ff == DIV) && div_done) begin
         if (job_ff < 4'd3) mean_ff[job_ff[1:0]] <= CW'(q_signed);
         else cov_ff[job_cov[2:0]] <= cov_res;
      end
      // deviation stage
      for (int c = 0; c < smc3_pkg::NUM_COMP; c++)
         dev_ff[c] <= $signed({mem_q_ff[c*CW+CW-1], mem_q_ff[c*CW +: CW]})
                    - $signed({mean_ff[c][CW-1], mean_ff[c]});
   end

   // sample store
   always_ff @(posedge clock) begin
      if (req_acc && (count_ff < CNTW'(MAX_SAMPLES))) store[count_ff[ADW-1:0]] <= wr_word;
      if (rd_on_ff) mem_q_ff <= store[rd_addr_ff[ADW-1:0]];
   end

   smc3_div #(.W(AW), .DVW(CNTW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   for (genvar k = 0; k < smc3_pkg::NUM_PAIR; k++) begin : g_lane
      smc3_lane #(.DW(DW), .AW(AW)) u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl),
         .dev_a (dev_ff[smc3_pkg::pair_row(k)]),
         .dev_b (dev_ff[smc3_pkg::pair_col(k)]),
         .busy  (lane_busy[k]),
         .acc   (lane_acc[k])
      );
   end

   // result row merge
   always_comb begin
      if (count_ff < CNTW'(2)) status = smc3_pkg::STATUS_TOO_FEW;
      else if (ovf_ff) status = smc3_pkg::STATUS_DROPPED;
      else status = smc3_pkg::STATUS_OK;
      mean_x = MXW'(mean_ff[row_ff]);
      if (mean_x > $signed(MXW'(32'h7fff_ffff))) mean_out = 32'h7fff_ffff;
      else if (mean_x < -$signed(MXW'(33'h1_0000_0000) >>> 1)) mean_out = 32'h8000_0000;
      else mean_out = mean_x[FW-1:0];
   end

   assign rsp_bus.valid      = (state_ff == EMIT);
   assign rsp_bus.row_index  = row_ff;
   assign rsp_bus.mean_value = mean_out;
   assign rsp_bus.cov_col0   = (status == smc3_pkg::STATUS_TOO_FEW) ? '0
                             : cov_ff[smc3_pkg::tri_index(row_ff, 2'd0)];
   assign rsp_bus.cov_col1   = (status == smc3_pkg::STATUS_TOO_FEW) ? '0
                             : cov_ff[smc3_pkg::tri_index(row_ff, 2'd1)];
   assign rsp_bus.cov_col2   = (status == smc3_pkg::STATUS_TOO_FEW) ? '0
                             : cov_ff[smc3_pkg::tri_index(row_ff, 2'd2)];
   assign rsp_bus.status     = status;
   assign rsp_bus.row_last   = (row_ff == 2'd2);

   a_phase_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !req_bus.ready)
      else $error("result beat offered while loading");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_SAMPLES))
      else $error("sample count beyond store depth");
   a_close: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_bus.row_last |=> (count_ff == '0) && !ovf_ff && req_bus.ready)
      else $error("set not cleared after last row");
   a_sweep_idle_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SWEEP) |-> !div_busy)
      else $error("divider running during sweep");
endmodule
`default_nettype wire
